// File: hdl/ir_pulse_distance_decoder_defines.svh
// Assertion macros shared by the IR pulse-distance decoder RTL.
// Expects clk and arst_n in the scope where a macro is used.
`ifndef IR_PULSE_DISTANCE_DECODER_DEFINES_SVH
`define IR_PULSE_DISTANCE_DECODER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define IRPDD_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define IRPDD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/irpdd_pkg.sv
// Package for the IR pulse-distance decoder: register map, result codes
// and the structs passed between modules. No dependencies.
`default_nettype none

package irpdd_pkg;

	// configuration port
	localparam int CFG_W     = 16;
	localparam int PDATA_W   = 32;
	localparam int PADDR_W   = 5;
	localparam int REG_IDX_W = 3;

	localparam logic [REG_IDX_W-1:0] REG_LEADER_MIN = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_LEADER_MAX = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_ZERO_MIN   = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_BIT_SPLIT  = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_ONE_MAX    = 3'd4;

	localparam logic [CFG_W-1:0] RST_LEADER_MIN = 16'd240;
	localparam logic [CFG_W-1:0] RST_LEADER_MAX = 16'd400;
	localparam logic [CFG_W-1:0] RST_ZERO_MIN   = 16'd20;
	localparam logic [CFG_W-1:0] RST_BIT_SPLIT  = 16'd30;
	localparam logic [CFG_W-1:0] RST_ONE_MAX    = 16'd60;

	// command byte position inside the frame word
	localparam int CODE_LSB = 16;
	localparam int CODE_W   = 8;

	// input command codes
	localparam logic CMD_EDGE  = 1'b0;
	localparam logic CMD_CLEAR = 1'b1;

	// result kinds
	localparam logic KIND_COMMAND = 1'b0;
	localparam logic KIND_CLEAR   = 1'b1;

	typedef struct packed {
		logic [CFG_W-1:0] leader_min;
		logic [CFG_W-1:0] leader_max;
		logic [CFG_W-1:0] zero_min;
		logic [CFG_W-1:0] bit_split;
		logic [CFG_W-1:0] one_max;
	} cfg_regs_t;

	typedef struct packed {
		logic              emit;
		logic              kind;
		logic [CODE_W-1:0] code;
	} step_res_t;

endpackage

`default_nettype wire

// File: hdl/ir_pulse_distance_decoder.sv
// Top level of the IR pulse-distance decoder: input register, decode core,
// result register and configuration port. Depends on irpdd_pkg, irpdd_cfg, irpdd_core.
`default_nettype none

// Decodes NEC-style pulse-distance frames from captured falling-edge timestamps.
// Each transaction on the input carries one edge (or a clear command); the block
// takes one transaction per clock cycle unless a result finds the result register
// full. An item passes the input register, where the gap test and the frame state
// update happen, then the result register. The state update in the core lets the
// next edge use the state the previous one left. A result is produced for the edge
// that ends a frame (the command byte) and for every edge seen while the alarm is
// active. Window registers are to be written over the APB port only while the block
// is idle; the block itself does not enforce this.
module ir_pulse_distance_decoder #(
	parameter int FRAME_BITS = 32,
	parameter int TIME_WIDTH = 16
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// input channel
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic                                cmd,
	input  wire logic [TIME_WIDTH-1:0]               edge_time,
	input  wire logic                                alarm_active,
	// result channel
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic                                     result_kind,
	output logic [irpdd_pkg::CODE_W-1:0]             command_code,
	// configuration port
	input  wire logic                                psel,
	input  wire logic                                penable,
	input  wire logic                                pwrite,
	input  wire logic [irpdd_pkg::PADDR_W-1:0]       paddr,
	input  wire logic [irpdd_pkg::PDATA_W-1:0]       pwdata,
	output logic      [irpdd_pkg::PDATA_W-1:0]       prdata,
	output logic                                     pready
);
	import irpdd_pkg::*;

	cfg_regs_t             regs;
	step_res_t             res;

	logic                  valid_s1;
	logic                  cmd_s1;
	logic [TIME_WIDTH-1:0] edge_time_s1;
	logic                  alarm_s1;

	logic                  out_valid_q;
	logic                  result_kind_q;
	logic [CODE_W-1:0]     command_code_q;

	logic                  out_free;
	logic                  step;
	logic                  load_in;
	logic                  load_out;

	irpdd_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.regs    (regs)
	);

	irpdd_core #(
		.FRAME_BITS (FRAME_BITS),
		.TIME_WIDTH (TIME_WIDTH)
	) u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (step),
		.cmd          (cmd_s1),
		.edge_time    (edge_time_s1),
		.alarm_active (alarm_s1),
		.regs         (regs),
		.res          (res)
	);

	// handshake: an item in s1 retires unless its result finds the output full
	assign out_free = !out_valid_q || out_ready;
	assign step     = valid_s1 && (!res.emit || out_free);
	assign in_ready = !valid_s1 || step;
	assign load_in  = in_valid && in_ready;
	assign load_out = step && res.emit;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_in) begin
			cmd_s1       <= cmd;
			edge_time_s1 <= edge_time;
			alarm_s1     <= alarm_active;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			result_kind_q  <= res.kind;
			command_code_q <= res.code;
		end
	end

	assign out_valid    = out_valid_q;
	assign result_kind  = result_kind_q;
	assign command_code = command_code_q;

endmodule

`default_nettype wire

// File: hdl/irpdd_cfg.sv
// APB-style configuration register file for the IR decoder windows.
// Depends on irpdd_pkg.
`default_nettype none

module irpdd_cfg (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [irpdd_pkg::PADDR_W-1:0]   paddr,
	input  wire logic [irpdd_pkg::PDATA_W-1:0]   pwdata,
	output logic      [irpdd_pkg::PDATA_W-1:0]   prdata,
	output logic                                 pready,
	output irpdd_pkg::cfg_regs_t                 regs
);
	import irpdd_pkg::*;

	cfg_regs_t             regs_q;
	logic [REG_IDX_W-1:0]  idx;
	logic                  wr_en;
	logic [CFG_W-1:0]      rd_val;

	assign pready = 1'b1;
	assign idx    = paddr[PADDR_W-1:2];
	assign wr_en  = psel & penable & pwrite & pready;
	assign regs   = regs_q;

	// register writes; unmapped indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.leader_min <= RST_LEADER_MIN;
			regs_q.leader_max <= RST_LEADER_MAX;
			regs_q.zero_min   <= RST_ZERO_MIN;
			regs_q.bit_split  <= RST_BIT_SPLIT;
			regs_q.one_max    <= RST_ONE_MAX;
		end else if (wr_en) begin
			case (idx)
				REG_LEADER_MIN: regs_q.leader_min <= pwdata[CFG_W-1:0];
				REG_LEADER_MAX: regs_q.leader_max <= pwdata[CFG_W-1:0];
				REG_ZERO_MIN:   regs_q.zero_min   <= pwdata[CFG_W-1:0];
				REG_BIT_SPLIT:  regs_q.bit_split  <= pwdata[CFG_W-1:0];
				REG_ONE_MAX:    regs_q.one_max    <= pwdata[CFG_W-1:0];
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		case (idx)
			REG_LEADER_MIN: rd_val = regs_q.leader_min;
			REG_LEADER_MAX: rd_val = regs_q.leader_max;
			REG_ZERO_MIN:   rd_val = regs_q.zero_min;
			REG_BIT_SPLIT:  rd_val = regs_q.bit_split;
			REG_ONE_MAX:    rd_val = regs_q.one_max;
			default:        rd_val = '0;
		endcase
	end

	assign prdata = PDATA_W'(rd_val);

endmodule

`default_nettype wire

// File: hdl/irpdd_core.sv
// Frame decode state and next-state logic for the IR decoder: gap windows,
// bit collection and command extraction. Depends on irpdd_pkg and the defines header.
`default_nettype none
`include "ir_pulse_distance_decoder_defines.svh"

module irpdd_core #(
	parameter int FRAME_BITS = 32,
	parameter int TIME_WIDTH = 16
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  step,
	input  wire logic                  cmd,
	input  wire logic [TIME_WIDTH-1:0] edge_time,
	input  wire logic                  alarm_active,
	input  wire irpdd_pkg::cfg_regs_t  regs,
	output irpdd_pkg::step_res_t       res
);
	import irpdd_pkg::*;

	localparam int CNT_W = $clog2(FRAME_BITS + 1);
	localparam int IDX_W = $clog2(FRAME_BITS);
	localparam int CMP_W = (TIME_WIDTH > CFG_W) ? TIME_WIDTH : CFG_W;
	localparam logic [CNT_W-1:0] BITS_FULL = CNT_W'(FRAME_BITS);

	localparam logic [1:0] PH_IDLE   = 2'd0;
	localparam logic [1:0] PH_LEADER = 2'd1;
	localparam logic [1:0] PH_DATA   = 2'd2;

	logic [TIME_WIDTH-1:0] last_q, last_d;
	logic [1:0]            phase_q, phase_d;
	logic [CNT_W-1:0]      bits_q, bits_d;
	logic [FRAME_BITS-1:0] frame_q, frame_d;

	logic [TIME_WIDTH-1:0] gap;
	logic [CMP_W-1:0]      gap_x;
	logic                  in_leader, in_zero, in_one;
	logic [CODE_W-1:0]     code_raw, code;

	// modulo gap and strict window tests
	assign gap       = edge_time - last_q;
	assign gap_x     = CMP_W'(gap);
	assign in_leader = (gap_x > CMP_W'(regs.leader_min)) && (gap_x < CMP_W'(regs.leader_max));
	assign in_zero   = (gap_x > CMP_W'(regs.zero_min)) && (gap_x < CMP_W'(regs.bit_split));
	assign in_one    = (gap_x > CMP_W'(regs.bit_split)) && (gap_x < CMP_W'(regs.one_max));

	// command byte; bits beyond the frame read as zero
	for (genvar i = 0; i < CODE_W; i++) begin : g_code
		if (CODE_LSB + i < FRAME_BITS) begin : g_in
			assign code_raw[i] = frame_q[CODE_LSB+i];
		end else begin : g_out
			assign code_raw[i] = 1'b0;
		end
	end
	assign code = (code_raw == '0) ? CODE_W'(1) : code_raw;

	// next state and result for the item at hand
	always_comb begin
		last_d   = last_q;
		phase_d  = phase_q;
		bits_d   = bits_q;
		frame_d  = frame_q;
		res.emit = 1'b0;
		res.kind = KIND_COMMAND;
		res.code = '0;
		if (cmd == CMD_CLEAR) begin
			last_d  = '0;
			phase_d = PH_IDLE;
			bits_d  = '0;
			frame_d = '0;
		end else if (alarm_active) begin
			res.emit = 1'b1;
			res.kind = KIND_CLEAR;
		end else begin
			case (phase_q)
				PH_LEADER: begin
					if (in_leader) begin
						last_d  = edge_time;
						phase_d = PH_DATA;
					end else begin
						last_d  = '0;
						phase_d = PH_IDLE;
					end
					bits_d  = '0;
					frame_d = '0;
				end
				PH_DATA: begin
					if (bits_q < BITS_FULL) begin
						if (in_zero || in_one) begin
							frame_d = frame_q | (FRAME_BITS'(in_one) << bits_q[IDX_W-1:0]);
							bits_d  = bits_q + CNT_W'(1);
							last_d  = edge_time;
						end else begin
							last_d  = '0;
							phase_d = PH_IDLE;
							bits_d  = '0;
							frame_d = '0;
						end
					end else begin
						res.emit = 1'b1;
						res.code = code;
						last_d   = '0;
						phase_d  = PH_IDLE;
						bits_d   = '0;
						frame_d  = '0;
					end
				end
				default: begin
					// idle: this edge opens a frame
					last_d  = edge_time;
					phase_d = PH_LEADER;
					bits_d  = '0;
					frame_d = '0;
				end
			endcase
		end
	end

	// decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q  <= '0;
			phase_q <= PH_IDLE;
			bits_q  <= '0;
			frame_q <= '0;
		end else if (step) begin
			last_q  <= last_d;
			phase_q <= phase_d;
			bits_q  <= bits_d;
			frame_q <= frame_d;
		end
	end

	`IRPDD_ASSERT_SAME(a_bits_bound, 1'b1, bits_q <= BITS_FULL, "bit count past frame length")
	`IRPDD_ASSERT_SAME(a_bits_in_data, bits_q != '0 || frame_q != '0, phase_q == PH_DATA, "bits held outside data phase")
	`IRPDD_ASSERT_SAME(a_emit_full, step && res.emit && res.kind == KIND_COMMAND, phase_q == PH_DATA && bits_q == BITS_FULL, "command emitted before frame complete")
	`IRPDD_ASSERT_NEXT(a_clear_idle, step && cmd == CMD_CLEAR, phase_q == PH_IDLE && bits_q == '0 && last_q == '0, "clear did not reset decoder")

endmodule

`default_nettype wire

// File: tb/sv/ir_pulse_distance_decoder_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for ir_pulse_distance_decoder: drives edge and clear
// transactions, predicts every decoded command and alarm notice, checks them in order.
// Depends on irpdd_pkg and the ir_pulse_distance_decoder RTL.

module ir_pulse_distance_decoder_tb;
	import irpdd_pkg::*;

	localparam int FRAME_BITS    = 32;
	localparam int TIME_W        = 16;
	localparam int REG_COUNT     = 5;
	localparam int MAX_PAUSE     = 10;
	localparam int LONG_HOLD     = 300;
	localparam int SETTLE_CYCLES = 8;
	localparam int CYCLE_LIMIT   = 500000;

	typedef enum logic [1:0] {PHASE_IDLE, PHASE_LEADER, PHASE_DATA} frame_phase_t;
	typedef enum {FRAME_WHOLE, FRAME_BAD_LEADER, FRAME_BAD_BIT, FRAME_CLEARED} frame_shape_t;

	typedef struct packed {
		logic              kind;
		logic [CODE_W-1:0] code;
	} decode_result_t;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	logic                cmd;
	logic [TIME_W-1:0]   edge_time;
	logic                alarm_active;
	logic                out_valid;
	logic                out_ready;
	logic                result_kind;
	logic [CODE_W-1:0]   command_code;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [PADDR_W-1:0]  paddr;
	logic [PDATA_W-1:0]  pwdata;
	logic [PDATA_W-1:0]  prdata;
	logic                pready;

	// decoder prediction state
	cfg_regs_t           windows;
	logic [TIME_W-1:0]   prev_edge;
	frame_phase_t        rx_phase;
	logic [5:0]          bit_count;
	logic [31:0]         shift_word;
	decode_result_t      pending_decodes[$];

	// stimulus state
	logic [TIME_W-1:0]   tick_now;
	bit                  tx_idle;
	bit                  rx_idle;
	bit                  hold_req;
	int                  edges_sent;
	int                  errors;
	int                  cycle_count;

	ir_pulse_distance_decoder dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.cmd          (cmd),
		.edge_time    (edge_time),
		.alarm_active (alarm_active),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.result_kind  (result_kind),
		.command_code (command_code),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	// 125 MHz clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// Prediction
	// ---------------------------------------------------------------

	function automatic void drop_frame();
		prev_edge  = '0;
		rx_phase   = PHASE_IDLE;
		bit_count  = '0;
		shift_word = '0;
	endfunction

	function automatic void restore_windows();
		windows.leader_min = RST_LEADER_MIN;
		windows.leader_max = RST_LEADER_MAX;
		windows.zero_min   = RST_ZERO_MIN;
		windows.bit_split  = RST_BIT_SPLIT;
		windows.one_max    = RST_ONE_MAX;
		drop_frame();
	endfunction

	// Advance the frame state by one accepted transaction; queue any result.
	function automatic void decode_edge(logic c, logic [TIME_W-1:0] t, logic alarm);
		logic [TIME_W-1:0] gap;
		logic [CODE_W-1:0] code;
		logic              bit_val;
		decode_result_t    res;
		gap = t - prev_edge;
		if (c == CMD_CLEAR) begin
			drop_frame();
			return;
		end
		// alarm: edge ignored, state untouched
		if (alarm) begin
			res.kind = KIND_CLEAR;
			res.code = '0;
			pending_decodes.push_back(res);
			return;
		end
		case (rx_phase)
			PHASE_LEADER: begin
				if (gap > windows.leader_min && gap < windows.leader_max) begin
					prev_edge  = t;
					rx_phase   = PHASE_DATA;
					bit_count  = '0;
					shift_word = '0;
				end else begin
					drop_frame();
				end
			end
			PHASE_DATA: begin
				if (bit_count < FRAME_BITS) begin
					if (gap > windows.zero_min && gap < windows.bit_split) begin
						bit_val = 1'b0;
					end else if (gap > windows.bit_split && gap < windows.one_max) begin
						bit_val = 1'b1;
					end else begin
						drop_frame();
						return;
					end
					shift_word[bit_count[4:0]] = bit_val;
					bit_count = bit_count + 6'd1;
					prev_edge = t;
				end else begin
					// terminating edge: gap not checked
					code = shift_word[CODE_LSB +: CODE_W];
					if (code == '0)
						code = 8'd1;
					drop_frame();
					res.kind = KIND_COMMAND;
					res.code = code;
					pending_decodes.push_back(res);
				end
			end
			default: begin
				// idle or unused phase: edge opens a frame
				prev_edge  = t;
				rx_phase   = PHASE_LEADER;
				bit_count  = '0;
				shift_word = '0;
			end
		endcase
	endfunction

	// ---------------------------------------------------------------
	// Result checking
	// ---------------------------------------------------------------

	// sampled mid-cycle; the transaction completes at the next rising edge
	always @(negedge clk) begin : check_decodes
		decode_result_t want;
		if (arst_n === 1'b1 && out_valid && out_ready) begin
			if (pending_decodes.size() == 0) begin
				$display("%0t ns: unexpected result, expected none, got kind %0d code 0x%02h",
					$time, result_kind, command_code);
				errors++;
			end else begin
				want = pending_decodes.pop_front();
				if (result_kind !== want.kind) begin
					$display("%0t ns: result_kind mismatch, expected %0d, got %0d",
						$time, want.kind, result_kind);
					errors++;
				end
				if (command_code !== want.code) begin
					$display("%0t ns: command_code mismatch, expected 0x%02h, got 0x%02h",
						$time, want.code, command_code);
					errors++;
				end
			end
		end
	end

	// Result side: random stall per transaction, plus a long hold on request
	initial begin : drive_out_ready
		int stall;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end
			stall = rx_idle ? $urandom_range(0, MAX_PAUSE) : 0;
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(negedge clk); while (!out_valid && !hold_req);
			@(posedge clk);
		end
	end

	// ---------------------------------------------------------------
	// Stimulus helpers
	// ---------------------------------------------------------------

	// One input transaction; returns at the edge where it was accepted.
	task automatic send_edge(logic c, logic [TIME_W-1:0] t, logic alarm);
		int pause;
		pause = tx_idle ? $urandom_range(0, MAX_PAUSE) : 0;
		if (pause > 0) begin
			in_valid <= 1'b0;
			repeat (pause) @(posedge clk);
		end
		in_valid     <= 1'b1;
		cmd          <= c;
		edge_time    <= t;
		alarm_active <= alarm;
		do @(negedge clk); while (!in_ready);
		@(posedge clk);
		decode_edge(c, t, alarm);
		edges_sent++;
	endtask

	task automatic send_after(logic [TIME_W-1:0] gap);
		tick_now += gap;
		send_edge(CMD_EDGE, tick_now, 1'b0);
	endtask

	// Stop offering input and wait until every result has come back.
	task automatic settle();
		in_valid <= 1'b0;
		while (pending_decodes.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= {16'($urandom), value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_LEADER_MIN: windows.leader_min = value;
			REG_LEADER_MAX: windows.leader_max = value;
			REG_ZERO_MIN:   windows.zero_min   = value;
			REG_BIT_SPLIT:  windows.bit_split  = value;
			REG_ONE_MAX:    windows.one_max    = value;
			default: ;
		endcase
	endtask

	task automatic program_windows(logic [CFG_W-1:0] lmin, logic [CFG_W-1:0] lmax,
		logic [CFG_W-1:0] zmin, logic [CFG_W-1:0] split, logic [CFG_W-1:0] omax);
		settle();
		write_reg(REG_LEADER_MIN, lmin);
		write_reg(REG_LEADER_MAX, lmax);
		write_reg(REG_ZERO_MIN, zmin);
		write_reg(REG_BIT_SPLIT, split);
		write_reg(REG_ONE_MAX, omax);
	endtask

	// Gap strictly inside (lo, hi) when that range is not empty, else hi; often right next to a bound.
	function automatic logic [TIME_W-1:0] gap_within(logic [TIME_W-1:0] lo,
		logic [TIME_W-1:0] hi);
		if (int'(hi) - int'(lo) < 2)
			return hi;
		case ($urandom_range(0, 5))
			0: return lo + 16'd1;
			1: return hi - 16'd1;
			default: return TIME_W'($urandom_range(int'(lo) + 1, int'(hi) - 1));
		endcase
	endfunction

	// Gap on or beyond either bound.
	function automatic logic [TIME_W-1:0] gap_outside(logic [TIME_W-1:0] lo,
		logic [TIME_W-1:0] hi);
		case ($urandom_range(0, 3))
			0: return lo;
			1: return hi;
			2: return TIME_W'($urandom_range(0, int'(lo)));
			default: return TIME_W'($urandom_range(int'(hi), 16'hFFFF));
		endcase
	endfunction

	// One frame under the current windows, whole or broken at a random bit.
	task automatic send_frame(logic [31:0] data, frame_shape_t shape);
		int                stop_at;
		int                i;
		logic [TIME_W-1:0] gap;
		stop_at = $urandom_range(0, FRAME_BITS - 1);
		send_after(16'($urandom));
		if (shape == FRAME_BAD_LEADER) begin
			send_after(gap_outside(windows.leader_min, windows.leader_max));
			return;
		end
		send_after(gap_within(windows.leader_min, windows.leader_max));
		for (i = 0; i < FRAME_BITS; i++) begin
			// edges during the alarm leave the frame intact
			if ($urandom_range(0, 19) == 0)
				send_edge(CMD_EDGE, 16'($urandom), 1'b1);
			if (i == stop_at && shape == FRAME_CLEARED) begin
				send_edge(CMD_CLEAR, 16'($urandom), 1'($urandom_range(0, 1)));
				return;
			end
			if (i == stop_at && shape == FRAME_BAD_BIT) begin
				if ($urandom_range(0, 3) == 0)
					gap = windows.bit_split;
				else
					gap = gap_outside(windows.zero_min, windows.one_max);
				send_after(gap);
				return;
			end
			if (data[i])
				send_after(gap_within(windows.bit_split, windows.one_max));
			else
				send_after(gap_within(windows.zero_min, windows.bit_split));
		end
		// terminating edge, any gap
		send_after(16'($urandom));
	endtask

	// ---------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------

	task automatic test_alarm_and_clear();
		tx_idle = 1'b0;
		rx_idle = 1'b1;
		send_edge(CMD_EDGE, '0, 1'b1);       // alarm while idle: notice only
		send_edge(CMD_CLEAR, '1, 1'b1);      // clear wins over the alarm
		tick_now = '1;
		send_edge(CMD_EDGE, tick_now, 1'b0); // frame start at top of the timer
		send_edge(CMD_EDGE, '0, 1'b1);       // alarm during leader is ignored
		send_after(16'd300);                 // leader gap wraps the timer
		send_after(16'd25);
		send_edge(CMD_CLEAR, 16'h5A5A, 1'b0); // clear mid-frame drops it
		send_after(16'd45);                  // opens a new frame from idle
		send_edge(CMD_EDGE, 16'hA5A5, 1'b1);
		send_edge(CMD_CLEAR, '0, 1'b0);
	endtask

	// every window bound is exclusive
	task automatic test_window_bounds();
		tx_idle = 1'b1;
		rx_idle = 1'b0;
		tick_now = 16'h1234;
		send_after(16'd7);
		send_after(windows.leader_min);
		send_after(16'd7);
		send_after(windows.leader_max);
		send_after(16'd7);
		send_after(windows.leader_min + 16'd1);
		send_after(windows.zero_min);
		send_after(16'd7);
		send_after(windows.leader_max - 16'd1);
		send_after(windows.bit_split);
		send_after(16'd7);
		send_after(windows.leader_min + 16'd1);
		send_after(windows.zero_min + 16'd1);
		send_after(windows.bit_split - 16'd1);
		send_after(windows.bit_split + 16'd1);
		send_after(windows.one_max - 16'd1);
		send_after(windows.one_max);
	endtask

	// Mostly well-formed frames with random content, some broken, some noise.
	task automatic test_random_frames(int n_items);
		int          stop;
		int          pick;
		logic [31:0] data;
		stop = edges_sent + n_items;
		while (edges_sent < stop) begin
			tx_idle = $urandom_range(0, 3) != 0;
			rx_idle = $urandom_range(0, 3) != 0;
			data = $urandom;
			case ($urandom_range(0, 7))
				0: data[CODE_LSB +: CODE_W] = '0;
				1: data[CODE_LSB +: CODE_W] = '1;
				default: ;
			endcase
			pick = $urandom_range(0, 11);
			if (pick < 7) begin
				send_frame(data, FRAME_WHOLE);
			end else if (pick == 7) begin
				send_frame(data, FRAME_BAD_LEADER);
			end else if (pick == 8) begin
				send_frame(data, FRAME_BAD_BIT);
			end else if (pick == 9) begin
				send_frame(data, FRAME_CLEARED);
			end else begin
				repeat ($urandom_range(1, 6))
					send_edge(($urandom_range(0, 3) == 0) ? CMD_CLEAR : CMD_EDGE,
						16'($urandom), 1'($urandom_range(0, 3) == 0));
			end
		end
	endtask

	// Receiver holds off while input keeps coming; then a full drain.
	task automatic test_backpressure();
		int i;
		settle();
		tx_idle = 1'b0;
		rx_idle = 1'b0;
		hold_req = 1'b1;
		for (i = 0; i < 40; i++)
			send_edge(CMD_EDGE, 16'($urandom), 1'b1);
		send_frame($urandom, FRAME_WHOLE);
		send_frame($urandom, FRAME_WHOLE);
		settle();
	endtask

	task automatic test_config_sweep();
		int                i;
		logic [CFG_W-1:0]  lmin;
		logic [CFG_W-1:0]  zmin;
		logic [CFG_W-1:0]  split;
		// widest windows; a zero bit only at gap 1
		program_windows(16'd0, 16'hFFFF, 16'd0, 16'd2, 16'hFFFF);
		test_random_frames(200);
		// writes past the register map change nothing
		settle();
		for (i = REG_COUNT; i < (1 << REG_IDX_W); i++)
			write_reg(i[REG_IDX_W-1:0], 16'($urandom));
		// one legal gap per window
		program_windows(16'd1000, 16'd1002, 16'd5, 16'd7, 16'd9);
		test_random_frames(200);
		// random ordered windows
		lmin  = CFG_W'($urandom_range(0, 60000));
		zmin  = CFG_W'($urandom_range(0, 200));
		split = zmin + 16'd2 + 16'($urandom_range(0, 200));
		program_windows(lmin, lmin + 16'd2 + 16'($urandom_range(0, 5000)), zmin, split,
			split + 16'd2 + 16'($urandom_range(0, 1000)));
		test_random_frames(200);
		// degenerate settings: no leader can pass
		program_windows('0, '0, '0, '0, '0);
		test_random_frames(12);
		program_windows('1, '1, '1, '1, '1);
		test_random_frames(12);
		program_windows(RST_LEADER_MIN, RST_LEADER_MAX, RST_ZERO_MIN, RST_BIT_SPLIT,
			RST_ONE_MAX);
		test_random_frames(40);
	endtask

	// ---------------------------------------------------------------
	// Sequence
	// ---------------------------------------------------------------

	initial begin
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		cmd          = CMD_EDGE;
		edge_time    = '0;
		alarm_active = 1'b0;
		psel         = 1'b0;
		penable      = 1'b0;
		pwrite       = 1'b0;
		paddr        = '0;
		pwdata       = '0;
		tick_now     = '0;
		restore_windows();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_alarm_and_clear();
		test_window_bounds();
		test_random_frames(320);
		test_backpressure();
		test_config_sweep();

		settle();
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
